### design/nec_ir_pkg.sv
// Shared constants and types for the NEC infrared frame decoder.
// No dependencies; every other design file imports this package.
package nec_ir_pkg;

    // Field widths of the event and result beats
    localparam int unsigned REQ_W   = 2;
    localparam int unsigned WIDTH_W = 14;
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned RPT_W   = 8;
    localparam int unsigned IDLE_W  = 4;

    // Frame format and timing
    localparam int unsigned CODE_BITS     = 32;
    localparam logic [IDLE_W-1:0] TIMEOUT_TICKS = IDLE_W'(10);
    localparam logic [RPT_W-1:0]  RPT_DIVISOR   = RPT_W'(3);
    localparam logic [7:0]        NEC_ADDRESS   = 8'h00;

    // Division of the repeat count by three as a multiply by 171 and a shift by 9,
    // exact for every 8-bit count.
    localparam logic [RPT_W-1:0]  RPT_DIV3_MUL   = RPT_W'(171);
    localparam int unsigned       RPT_DIV3_SHIFT = 9;

    // Event codes
    localparam logic [REQ_W-1:0] EVT_RISE  = 2'd0;
    localparam logic [REQ_W-1:0] EVT_FALL  = 2'd1;
    localparam logic [REQ_W-1:0] EVT_TICK  = 2'd2;
    localparam logic [REQ_W-1:0] EVT_QUERY = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_NUM = 8;
    localparam int unsigned CFG_IDX_W = $clog2(CFG_NUM);
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_MAX    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MIN   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MAX   = 3'd7;

    typedef logic [WIDTH_W-1:0] width_t;

    // Reset values of the window registers, in index order
    localparam width_t CFG_RESET [CFG_NUM] = '{
        WIDTH_W'(300),  WIDTH_W'(800),  WIDTH_W'(1400), WIDTH_W'(1800),
        WIDTH_W'(2201), WIDTH_W'(2600), WIDTH_W'(4200), WIDTH_W'(4700)
    };

endpackage

### design/nec_ir_if.sv
// Valid/ready channel interfaces for the event and result beats.
// Depends on nec_ir_pkg for field widths.
interface nec_ir_evt_if import nec_ir_pkg::*;;
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [WIDTH_W-1:0] pulse_width;

    modport source (output valid, output req_type, output pulse_width, input ready);
    modport sink   (input valid, input req_type, input pulse_width, output ready);
endinterface

interface nec_ir_res_if import nec_ir_pkg::*;;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key;
    logic             frame_ready;
    logic             lead_seen;
    logic [RPT_W-1:0] repeat_count;

    modport source (output valid, output key, output frame_ready, output lead_seen,
                    output repeat_count, input ready);
    modport sink   (input valid, input key, input frame_ready, input lead_seen,
                    input repeat_count, output ready);
endinterface

### design/nec_ir_frame_decoder.sv
// NEC infrared frame decoder top level.
// Depends on nec_ir_pkg and the channel interfaces in nec_ir_if.sv.
//
// Usage:
//   evt carries one pulse event per beat: a rising edge, a falling edge with
//   the measured high width in microseconds, a 10 ms tick, or a decode query.
//   res returns exactly one beat per event: the decoded key (0 unless a valid
//   query), the frame-ready and lead-seen flags and the repeat count after
//   the event. The eight window registers are written through cfg_we/
//   cfg_index/cfg_wdata, by the user only while no event is in flight; the
//   block does not enforce this. A write lands at the clock edge.
// Timing:
//   An event passes from event beat to result beat through one input register
//   and one result register. One event is accepted every cycle while res is not
//   stalled; the state update is a read-modify-write of a few small registers.
// Reset:
//   rst_n clears all frame state and the pipeline valids, and loads the
//   default windows (zero 300..800, one 1400..1800, repeat 2201..2600,
//   lead 4200..4700).
// Backpressure:
//   When res is stalled the result register holds, the input register still
//   takes one more event, and evt.ready then drops until the result leaves.
module nec_ir_frame_decoder import nec_ir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_wdata,
    nec_ir_evt_if.sink           evt,
    nec_ir_res_if.source         res
);

    // Window registers
    width_t cfg_reg [CFG_NUM];

    // Input stage
    logic               in_valid_reg;
    logic [REQ_W-1:0]   in_type_reg;
    width_t             in_width_reg;

    // Frame state
    logic               lead_reg, lead_next;
    logic               ready_reg, ready_next;
    logic               pending_reg, pending_next;
    logic [IDLE_W-1:0]  idle_reg, idle_next;
    logic [CODE_BITS-1:0] code_reg, code_next;
    logic [RPT_W-1:0]   rpt_reg, rpt_next;

    // Result stage
    logic               out_valid_reg;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic               out_ready_reg;
    logic               out_lead_reg;
    logic [RPT_W-1:0]   out_rpt_reg;

    logic out_free;
    logic in_move;
    logic evt_accept;
    logic hit_zero, hit_one, hit_repeat, hit_lead;
    logic [7:0] addr_byte, addr_inv, cmd_byte, cmd_inv;
    logic frame_ok;
    logic [2*RPT_W-1:0] rpt_prod;
    logic [RPT_W-1:0]   rpt_third;

    // Handshake: the result register frees when empty or taken
    assign out_free   = !out_valid_reg || res.ready;
    assign in_move    = in_valid_reg && out_free;
    assign evt.ready  = !in_valid_reg || out_free;
    assign evt_accept = evt.valid && evt.ready;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CFG_NUM; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (evt_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_accept)
        begin
            in_type_reg  <= evt.req_type;
            in_width_reg <= evt.pulse_width;
        end
    end

    // Window classification, each window inclusive at both ends
    assign hit_zero   = (in_width_reg >= cfg_reg[CFG_ZERO_MIN])
                     && (in_width_reg <= cfg_reg[CFG_ZERO_MAX]);
    assign hit_one    = (in_width_reg >= cfg_reg[CFG_ONE_MIN])
                     && (in_width_reg <= cfg_reg[CFG_ONE_MAX]);
    assign hit_repeat = (in_width_reg >= cfg_reg[CFG_REPEAT_MIN])
                     && (in_width_reg <= cfg_reg[CFG_REPEAT_MAX]);
    assign hit_lead   = (in_width_reg >= cfg_reg[CFG_LEAD_MIN])
                     && (in_width_reg <= cfg_reg[CFG_LEAD_MAX]);

    // Frame check: fixed address with its inverse, command with its inverse
    assign addr_byte = code_reg[31:24];
    assign addr_inv  = code_reg[23:16];
    assign cmd_byte  = code_reg[15:8];
    assign cmd_inv   = code_reg[7:0];
    assign frame_ok  = (addr_byte == NEC_ADDRESS) && (addr_byte == ~addr_inv)
                    && (cmd_byte == ~cmd_inv);

    // Repeat count divided by three through a reciprocal multiply
    assign rpt_prod  = (2*RPT_W)'(rpt_reg) * (2*RPT_W)'(RPT_DIV3_MUL);
    assign rpt_third = RPT_W'(rpt_prod >> RPT_DIV3_SHIFT);

    // Next frame state and key for the event in the input register
    always_comb
    begin
        lead_next    = lead_reg;
        ready_next   = ready_reg;
        pending_next = pending_reg;
        idle_next    = idle_reg;
        code_next    = code_reg;
        rpt_next     = rpt_reg;
        key_next     = '0;

        case (in_type_reg)
            EVT_RISE:
            begin
                pending_next = 1'b1;
            end
            EVT_FALL:
            begin
                pending_next = 1'b0;
                if (pending_reg)
                begin
                    if (lead_reg)
                    begin
                        if (hit_zero)
                        begin
                            code_next = {code_reg[CODE_BITS-2:0], 1'b0};
                        end
                        else if (hit_one)
                        begin
                            code_next = {code_reg[CODE_BITS-2:0], 1'b1};
                        end
                        else if (hit_repeat)
                        begin
                            rpt_next  = rpt_reg + RPT_W'(1);
                            idle_next = '0;
                        end
                    end
                    else if (hit_lead)
                    begin
                        lead_next = 1'b1;
                        rpt_next  = '0;
                    end
                end
            end
            EVT_TICK:
            begin
                if (lead_reg)
                begin
                    pending_next = 1'b0;
                    if (idle_reg == '0)
                    begin
                        ready_next = 1'b1;
                    end
                    if (idle_reg < TIMEOUT_TICKS)
                    begin
                        idle_next = idle_reg + IDLE_W'(1);
                    end
                    else
                    begin
                        lead_next = 1'b0;
                        idle_next = '0;
                        rpt_next  = rpt_third;
                    end
                end
            end
            EVT_QUERY:
            begin
                if (ready_reg && !lead_reg)
                begin
                    if (frame_ok)
                    begin
                        key_next = cmd_byte;
                    end
                    if (rpt_reg == '0)
                    begin
                        ready_next = 1'b0;
                    end
                    else
                    begin
                        rpt_next = rpt_reg - RPT_W'(1);
                    end
                end
            end
            default:
            begin
                pending_next = pending_reg;
            end
        endcase
    end

    // Frame state update as the event moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg    <= 1'b0;
            ready_reg   <= 1'b0;
            pending_reg <= 1'b0;
            idle_reg    <= '0;
            code_reg    <= '0;
            rpt_reg     <= '0;
        end
        else if (in_move)
        begin
            lead_reg    <= lead_next;
            ready_reg   <= ready_next;
            pending_reg <= pending_next;
            idle_reg    <= idle_next;
            code_reg    <= code_next;
            rpt_reg     <= rpt_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_move)
        begin
            key_reg       <= key_next;
            out_ready_reg <= ready_next;
            out_lead_reg  <= lead_next;
            out_rpt_reg   <= rpt_next;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.key          = key_reg;
    assign res.frame_ready  = out_ready_reg;
    assign res.lead_seen    = out_lead_reg;
    assign res.repeat_count = out_rpt_reg;

endmodule

### test/nec_ir_frame_decoder_tb.sv
// Self-checking testbench for the NEC infrared frame decoder.
// Depends on nec_ir_pkg, the channel interfaces in nec_ir_if.sv and the decoder top level.
// Drives directed and random pulse-event beats and checks every result against a local model.
module nec_ir_frame_decoder_tb import nec_ir_pkg::*;;

    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned MAX_REPORTS   = 10;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        width_t           pulse_width;
    } ir_event_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             frame_ready;
        logic             lead_seen;
        logic [RPT_W-1:0] repeat_count;
    } ir_result_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WIDTH_W-1:0]   cfg_wdata;

    nec_ir_evt_if evt_ch ();
    nec_ir_res_if res_ch ();

    nec_ir_frame_decoder DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .evt       (evt_ch.sink),
        .res       (res_ch.source)
    );

    // Stimulus and checking stores.
    ir_event_t  pending_events [$];
    ir_result_t predicted_results [$];
    ir_event_t  offered;
    int unsigned queued_count;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    // Idling control.
    logic        gaps_on;
    logic        rx_long_hold_req;
    logic        rx_long_hold_done;
    int unsigned tx_gap;
    int unsigned rx_stall;

    // Local copy of the decoder state and windows.
    width_t            win [CFG_NUM];
    logic              st_lead;
    logic              st_ready;
    logic              st_high;
    logic [IDLE_W-1:0] st_idle;
    logic [31:0]       st_code;
    logic [RPT_W-1:0]  st_rpt;

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit width_in_window(width_t w, logic [CFG_IDX_W-1:0] lo_idx,
                                           logic [CFG_IDX_W-1:0] hi_idx);
        return (w >= win[lo_idx]) && (w <= win[hi_idx]);
    endfunction

    // Applies one event to the local state and returns the result beat it causes.
    function automatic ir_result_t decode_event_result(ir_event_t ev);
        ir_result_t r;
        r.key = '0;
        case (ev.req_type)
            EVT_RISE:
            begin
                st_high = 1'b1;
            end
            EVT_FALL:
            begin
                if (st_high)
                begin
                    if (st_lead)
                    begin
                        if (width_in_window(ev.pulse_width, CFG_ZERO_MIN, CFG_ZERO_MAX))
                            st_code = {st_code[30:0], 1'b0};
                        else if (width_in_window(ev.pulse_width, CFG_ONE_MIN, CFG_ONE_MAX))
                            st_code = {st_code[30:0], 1'b1};
                        else if (width_in_window(ev.pulse_width, CFG_REPEAT_MIN,
                                                 CFG_REPEAT_MAX))
                        begin
                            st_rpt  = st_rpt + RPT_W'(1);
                            st_idle = '0;
                        end
                    end
                    else if (width_in_window(ev.pulse_width, CFG_LEAD_MIN, CFG_LEAD_MAX))
                    begin
                        st_lead = 1'b1;
                        st_rpt  = '0;
                    end
                end
                st_high = 1'b0;
            end
            EVT_TICK:
            begin
                if (st_lead)
                begin
                    st_high = 1'b0;
                    if (st_idle == '0)
                        st_ready = 1'b1;
                    if (st_idle < TIMEOUT_TICKS)
                        st_idle = st_idle + IDLE_W'(1);
                    else
                    begin
                        st_lead = 1'b0;
                        st_idle = '0;
                        st_rpt  = st_rpt / RPT_DIVISOR;
                    end
                end
            end
            default:
            begin
                if (st_ready && !st_lead)
                begin
                    if (st_code[31:24] == NEC_ADDRESS && st_code[31:24] == ~st_code[23:16]
                        && st_code[15:8] == ~st_code[7:0])
                        r.key = st_code[15:8];
                    if (st_rpt == '0)
                        st_ready = 1'b0;
                    else
                        st_rpt = st_rpt - RPT_W'(1);
                end
            end
        endcase
        r.frame_ready  = st_ready;
        r.lead_seen    = st_lead;
        r.repeat_count = st_rpt;
        return r;
    endfunction

    function automatic int unsigned pick_tx_gap();
        int unsigned r;
        if (!gaps_on)
            return 0;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 12);
    endfunction

    // Driver: offers the oldest pending event and records the prediction on each accepted beat.
    always @(posedge clk)
    begin
        if (!rst_n)
            evt_ch.valid <= 1'b0;
        else
        begin
            if (evt_ch.valid && evt_ch.ready)
                predicted_results.push_back(decode_event_result(offered));
            if (!evt_ch.valid || evt_ch.ready)
            begin
                if (tx_gap != 0)
                begin
                    tx_gap = tx_gap - 1;
                    evt_ch.valid <= 1'b0;
                end
                else if (pending_events.size() != 0)
                begin
                    offered = pending_events.pop_front();
                    evt_ch.valid       <= 1'b1;
                    evt_ch.req_type    <= offered.req_type;
                    evt_ch.pulse_width <= offered.pulse_width;
                    tx_gap = pick_tx_gap();
                end
                else
                    evt_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver ready: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (rx_long_hold_req && !rx_long_hold_done)
        begin
            rx_long_hold_done <= 1'b1;
            rx_stall = LONG_HOLD;
            res_ch.ready <= 1'b0;
        end
        else if (rx_stall != 0)
        begin
            rx_stall = rx_stall - 1;
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
            if (gaps_on)
            begin
                case ($urandom_range(99)) inside
                    [0:17]:  rx_stall = $urandom_range(3, 1);
                    [18:20]: rx_stall = $urandom_range(60, 15);
                    default: rx_stall = 0;
                endcase
            end
        end
    end

    // Monitor: compares each result beat with the oldest prediction.
    always @(posedge clk)
    begin
        ir_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("cycle %0d: result beat with no prediction (key %0d)",
                             cycle_count, res_ch.key);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (res_ch.key !== want.key || res_ch.frame_ready !== want.frame_ready
                    || res_ch.lead_seen !== want.lead_seen
                    || res_ch.repeat_count !== want.repeat_count)
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $write("cycle %0d: exp key %0d ready %0b lead %0b rpt %0d, ",
                               cycle_count, want.key, want.frame_ready, want.lead_seen,
                               want.repeat_count);
                        $display("got key %0d ready %0b lead %0b rpt %0d",
                                 res_ch.key, res_ch.frame_ready, res_ch.lead_seen,
                                 res_ch.repeat_count);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("nec_ir_frame_decoder_tb NOT OK");
            $finish;
        end
    end

    task automatic push_event(input logic [REQ_W-1:0] req, input int unsigned w);
        ir_event_t ev;
        ev.req_type    = req;
        ev.pulse_width = width_t'(w);
        pending_events.push_back(ev);
        queued_count = queued_count + 1;
    endtask

    function automatic width_t width_from(logic [CFG_IDX_W-1:0] lo_idx,
                                          logic [CFG_IDX_W-1:0] hi_idx);
        if (win[lo_idx] > win[hi_idx])
            return width_t'($urandom_range(16383));
        return width_t'($urandom_range(win[hi_idx], win[lo_idx]));
    endfunction

    // Pushes a pulse pair: rising edge with a junk width, then the falling edge.
    task automatic push_pulse(input width_t w);
        push_event(EVT_RISE, $urandom_range(16383));
        push_event(EVT_FALL, w);
    endtask

    // A whole frame: lead, code bits, repeats with stray ticks, ticks, then queries.
    task automatic push_frame(input logic [31:0] code, input int unsigned n_bits,
                              input int unsigned n_rep, input bit full_ticks);
        int unsigned n_ticks;
        int unsigned n_query;
        push_pulse(width_from(CFG_LEAD_MIN, CFG_LEAD_MAX));
        for (int b = n_bits - 1; b >= 0; b--)
            push_pulse(code[b % 32] ? width_from(CFG_ONE_MIN, CFG_ONE_MAX)
                                    : width_from(CFG_ZERO_MIN, CFG_ZERO_MAX));
        for (int unsigned r = 0; r < n_rep; r++)
        begin
            if ($urandom_range(9) == 0)
                push_event(EVT_TICK, $urandom_range(16383));
            push_pulse(width_from(CFG_REPEAT_MIN, CFG_REPEAT_MAX));
        end
        n_ticks = full_ticks ? TIMEOUT_TICKS + 1 : $urandom_range(TIMEOUT_TICKS, 1);
        for (int unsigned t = 0; t < n_ticks; t++)
            push_event(EVT_TICK, $urandom_range(16383));
        // A query while the frame is still open must be refused.
        if (!full_ticks)
            push_event(EVT_QUERY, $urandom_range(16383));
        n_query = (n_rep % 256) / 3 + $urandom_range(2, 1);
        for (int unsigned q = 0; q < n_query; q++)
            push_event(EVT_QUERY, $urandom_range(16383));
    endtask

    // Random traffic: mostly well-formed frames, some broken frames and raw noise.
    task automatic run_random(input int unsigned n_items);
        int unsigned goal;
        int unsigned pick;
        logic [7:0]  cmd;
        logic [31:0] code;
        goal = queued_count + n_items;
        for (int unsigned t = 0; t < TIMEOUT_TICKS + 1; t++)
            push_event(EVT_TICK, $urandom_range(16383));
        while (queued_count < goal)
        begin
            pick = $urandom_range(99);
            cmd  = ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
            code = {NEC_ADDRESS, ~NEC_ADDRESS, cmd, ~cmd};
            if (pick < 60)
                push_frame(code, 32, $urandom_range(4), $urandom_range(5) != 0);
            else if (pick < 78)
            begin
                if ($urandom_range(1) == 0)
                    code = $urandom;
                else
                    code[$urandom_range(31)] = ~code[$urandom_range(31)];
                push_frame(code, $urandom_range(40), $urandom_range(3),
                           $urandom_range(3) != 0);
            end
            else
            begin
                for (int unsigned n = $urandom_range(10, 4); n != 0; n--)
                    push_event(2'($urandom_range(3)), $urandom_range(16383));
            end
        end
    endtask

    task automatic write_all(input width_t vals [CFG_NUM]);
        for (int i = 0; i < CFG_NUM; i++)
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            win[i] = vals[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sender pause: waits until every prediction has been matched, then settles.
    task automatic drain();
        while (!(pending_events.size() == 0 && !evt_ch.valid && predicted_results.size() == 0))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        width_t cfg_set [CFG_NUM];
        width_t swap_val;

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        evt_ch.valid = 1'b0;
        evt_ch.req_type = EVT_RISE;
        evt_ch.pulse_width = '0;
        res_ch.ready = 1'b0;
        gaps_on = 1'b1;
        rx_long_hold_req = 1'b0;
        rx_long_hold_done = 1'b0;
        tx_gap = 0;
        rx_stall = 0;
        queued_count = 0;
        mismatch_count = 0;
        cycle_count = 0;
        for (int i = 0; i < CFG_NUM; i++)
            win[i] = CFG_RESET[i];
        st_lead = 1'b0;
        st_ready = 1'b0;
        st_high = 1'b0;
        st_idle = '0;
        st_code = '0;
        st_rpt = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset windows.
        push_event(EVT_FALL, 4500);        // falling edge with no rising edge
        push_event(EVT_TICK, 0);           // tick before any lead
        push_event(EVT_QUERY, 16383);      // query with nothing ready
        push_pulse(16383);                 // widest width, no window
        push_pulse(0);                     // narrowest width, no window
        push_pulse(4199);                  // just under the lead window
        push_pulse(4200);                  // lead
        push_event(EVT_QUERY, 0);          // query during the frame
        push_pulse(800);                   // zero, top edge
        push_pulse(1400);                  // one, bottom edge
        push_pulse(2200);                  // just under the repeat window
        push_pulse(2201);                  // repeat
        push_pulse(4700);                  // lead width after the lead: ignored
        push_event(EVT_TICK, 16383);       // first tick marks ready
        push_event(EVT_QUERY, 1234);       // ready, but the frame is still open
        push_event(EVT_RISE, 0);
        push_event(EVT_TICK, 0);           // tick drops the armed pulse
        push_event(EVT_FALL, 300);
        run_random(70);
        drain();

        // Extreme windows covering the whole width range.
        cfg_set = '{0, 100, 101, 1000, 1001, 5000, 5001, 16383};
        write_all(cfg_set);
        run_random(70);
        drain();

        // Overlapping windows: zero wins over one, everything else is a repeat.
        cfg_set = '{300, 1500, 1000, 1800, 0, 16383, 16000, 16383};
        write_all(cfg_set);
        run_random(70);
        drain();

        // Inverted one and repeat windows match nothing.
        cfg_set = '{300, 800, 1800, 1400, 3000, 2000, 4200, 4700};
        write_all(cfg_set);
        run_random(70);
        drain();

        // Random ordered windows, with no idling on either side.
        for (int i = 0; i < CFG_NUM; i++)
            cfg_set[i] = width_t'($urandom_range(16383));
        for (int i = 0; i < CFG_NUM; i++)
            for (int j = 0; j < CFG_NUM - 1 - i; j++)
                if (cfg_set[j] > cfg_set[j+1])
                begin
                    swap_val = cfg_set[j];
                    cfg_set[j] = cfg_set[j+1];
                    cfg_set[j+1] = swap_val;
                end
        gaps_on <= 1'b0;
        write_all(cfg_set);
        run_random(70);
        drain();

        // Back to the reset windows: a repeat burst while the receiver holds off
        // long enough to back up the input.
        gaps_on <= 1'b1;
        write_all(CFG_RESET);
        push_frame({NEC_ADDRESS, ~NEC_ADDRESS, 8'h5A, 8'hA5}, 32, 20, 1'b1);
        rx_long_hold_req <= 1'b1;
        drain();

        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("nec_ir_frame_decoder_tb OK");
        else
            $display("nec_ir_frame_decoder_tb NOT OK");
        $finish;
    end

endmodule
